// ===== src/lurs_pkg.sv =====
`default_nettype none

package lurs_pkg;

    typedef enum logic [1:0] {
        CMD_PUT,
        CMD_IRQ,
        CMD_STEP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [3:0] row;
        logic [3:0] col;
        logic [7:0] rgb;
        logic       link_clr;
        logic       link_set;
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_PROBE  = 2'd1,
        KIND_HEADER = 2'd2,
        KIND_DATA   = 2'd3
    } t_byte_kind;

    localparam logic [1:0] REQ_PUT = 2'd0;
    localparam logic [1:0] REQ_IRQ = 2'd1;

    localparam logic [7:0] PROBE_BYTE  = 8'h20;
    localparam logic [7:0] HEADER_BASE = 8'h40;

    localparam logic [2:0] LS_FIND      = 3'd0;
    localparam logic [2:0] LS_STBY      = 3'd1;
    localparam logic [2:0] LS_BUILD     = 3'd2;
    localparam logic [2:0] LS_WAIT_TX   = 3'd3;
    localparam logic [2:0] LS_SEND      = 3'd4;
    localparam logic [2:0] LS_WAIT_DONE = 3'd5;

endpackage

`default_nettype wire

// ===== src/lurs_ram.sv =====
`default_nettype none

module lurs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/lurs_front.sv =====
`default_nettype none

module lurs_front
    import lurs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [3:0] i_row,
    input  logic [3:0] i_col,
    input  logic [7:0] i_rgb,
    input  logic       i_max_retry,
    input  logic       i_send_ready,
    input  logic       i_read_ready,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_ready
);

    localparam logic [1:0] SLOTS = 2'd2;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    t_cmd       cmd_in;
    logic       push;
    logic       pop;

    always_comb begin
        cmd_in.row      = i_row;
        cmd_in.col      = i_col;
        cmd_in.rgb      = i_rgb;
        cmd_in.link_clr = i_max_retry;
        cmd_in.link_set = i_send_ready | i_read_ready;
        case (i_req_type)
            REQ_PUT: cmd_in.kind = CMD_PUT;
            REQ_IRQ: cmd_in.kind = CMD_IRQ;
            default: cmd_in.kind = CMD_STEP;
        endcase
    end

    assign o_in_ready  = (r_fill != SLOTS);
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_fill <= r_fill + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

// ===== src/lurs_back.sv =====
`default_nettype none

module lurs_back
    import lurs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128,
    parameter int PAYLOAD_MAX = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_cmd       i_cmd,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_byte_kind,
    output logic [7:0] o_radio_byte,
    output logic       o_last,
    output logic [2:0] o_ctrl_state_out,
    output logic       o_link_up_out,
    output logic       o_dropped,
    output logic [7:0] o_queue_level
);

    localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
    localparam int HALF = PAYLOAD_MAX / 2;
    localparam int PAW  = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int PEW  = $clog2(HALF + 1);
    localparam int PLW  = $clog2(PAYLOAD_MAX + 1);

    typedef enum logic [2:0] {
        B_IDLE,
        B_STEP,
        B_BUILD,
        B_HDR,
        B_PROBE,
        B_SEND,
        B_NONE
    } t_bstate;

    t_bstate    r_bstate, n_bstate;
    logic [2:0] r_ctrl, n_ctrl;
    logic       r_link, n_link;
    logic       r_on_irq, n_on_irq;
    logic       r_drop, n_drop;
    logic [QCW-1:0] r_count, n_count;
    logic [QAW-1:0] r_head, n_head;
    logic [QAW-1:0] r_tail, n_tail;
    logic [PLW-1:0] r_plen, n_plen;
    logic [PEW-1:0] r_pk, n_pk;
    logic [PLW-1:0] r_sk, n_sk;

    logic       r_out_valid, n_out_valid;
    t_byte_kind r_out_kind, n_out_kind;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;
    logic [2:0] r_out_state, n_out_state;
    logic       r_out_link, n_out_link;
    logic       r_out_drop, n_out_drop;
    logic [7:0] r_out_level, n_out_level;

    logic           out_free;
    logic           uq_we;
    logic [15:0]    uq_rdata;
    logic           pl_we;
    logic [15:0]    pl_rdata;
    logic [PAW-1:0] pl_raddr;
    logic [PLW-1:0] sk_half;
    logic [QCW+7:0] lvl_ext;

    lurs_ram #(
        .WIDTH (16),
        .DEPTH (QUEUE_DEPTH)
    ) u_update_ram (
        .i_clk   (i_clk),
        .i_we    (uq_we),
        .i_waddr (r_tail),
        .i_wdata ({i_cmd.row, i_cmd.col, i_cmd.rgb}),
        .i_raddr (n_head),
        .o_rdata (uq_rdata)
    );

    lurs_ram #(
        .WIDTH (16),
        .DEPTH (HALF)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (r_pk[PAW-1:0]),
        .i_wdata (uq_rdata),
        .i_raddr (pl_raddr),
        .o_rdata (pl_rdata)
    );

    assign sk_half  = n_sk >> 1;
    assign pl_raddr = sk_half[PAW-1:0];
    assign out_free = !r_out_valid || i_out_ready;
    assign lvl_ext  = {8'd0, r_count};

    always_comb begin
        n_bstate    = r_bstate;
        n_ctrl      = r_ctrl;
        n_link      = r_link;
        n_on_irq    = r_on_irq;
        n_drop      = r_drop;
        n_count     = r_count;
        n_head      = r_head;
        n_tail      = r_tail;
        n_plen      = r_plen;
        n_pk        = r_pk;
        n_sk        = r_sk;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_state = r_out_state;
        n_out_link  = r_out_link;
        n_out_drop  = r_out_drop;
        n_out_level = r_out_level;
        uq_we       = 1'b0;
        pl_we       = 1'b0;
        o_cmd_ready = 1'b0;

        case (r_bstate)
            B_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_drop   = 1'b0;
                    n_on_irq = (i_cmd.kind == CMD_IRQ);
                    n_bstate = B_STEP;
                    case (i_cmd.kind)
                        CMD_PUT: begin
                            if (r_count != QCW'(QUEUE_DEPTH)) begin
                                uq_we   = 1'b1;
                                n_count = r_count + 1'b1;
                                n_tail  = (r_tail == QAW'(QUEUE_DEPTH - 1)) ? '0
                                                                            : r_tail + 1'b1;
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        CMD_IRQ: begin
                            if (i_cmd.link_set) begin
                                n_link = 1'b1;
                            end else if (i_cmd.link_clr) begin
                                n_link = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            B_STEP: begin
                case (r_ctrl)
                    LS_FIND: begin
                        if (r_link) begin
                            n_ctrl   = LS_STBY;
                            n_bstate = B_NONE;
                        end else begin
                            n_bstate = B_PROBE;
                        end
                    end
                    LS_STBY: begin
                        if (r_count != '0) begin
                            n_ctrl = LS_BUILD;
                        end
                        n_bstate = B_NONE;
                    end
                    LS_BUILD: begin
                        n_ctrl = LS_WAIT_TX;
                        if (r_count != '0) begin
                            n_pk     = '0;
                            n_plen   = '0;
                            n_bstate = B_BUILD;
                        end else begin
                            n_bstate = B_HDR;
                        end
                    end
                    LS_WAIT_TX: begin
                        // interrupt: move on and take one more step
                        if (r_on_irq) begin
                            n_ctrl   = r_link ? LS_SEND : LS_FIND;
                            n_on_irq = 1'b0;
                        end else begin
                            n_bstate = B_NONE;
                        end
                    end
                    LS_SEND: begin
                        n_ctrl   = LS_WAIT_DONE;
                        n_sk     = '0;
                        n_bstate = (r_plen != '0) ? B_SEND : B_NONE;
                    end
                    LS_WAIT_DONE: begin
                        if (r_on_irq) begin
                            n_ctrl   = LS_FIND;
                            n_on_irq = 1'b0;
                        end else begin
                            n_bstate = B_NONE;
                        end
                    end
                    default: begin
                        n_ctrl   = LS_FIND;
                        n_bstate = B_NONE;
                    end
                endcase
            end
            B_BUILD: begin
                pl_we   = 1'b1;
                n_head  = (r_head == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                n_count = r_count - 1'b1;
                n_pk    = r_pk + 1'b1;
                n_plen  = r_plen + PLW'(2);
                if (r_count == QCW'(1) || r_pk == PEW'(HALF - 1)) begin
                    n_bstate = B_HDR;
                end
            end
            B_HDR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_HEADER;
                    n_out_byte  = HEADER_BASE + 8'(r_plen);
                    n_out_last  = 1'b1;
                    n_bstate    = B_IDLE;
                end
            end
            B_PROBE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_PROBE;
                    n_out_byte  = PROBE_BYTE;
                    n_out_last  = 1'b1;
                    n_bstate    = B_IDLE;
                end
            end
            B_SEND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_DATA;
                    n_out_byte  = r_sk[0] ? pl_rdata[7:0] : pl_rdata[15:8];
                    n_out_last  = ((r_sk + PLW'(1)) == r_plen);
                    n_sk        = r_sk + PLW'(1);
                    if ((r_sk + PLW'(1)) == r_plen) begin
                        n_bstate = B_IDLE;
                    end
                end
            end
            B_NONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_NONE;
                    n_out_byte  = 8'd0;
                    n_out_last  = 1'b1;
                    n_bstate    = B_IDLE;
                end
            end
            default: n_bstate = B_IDLE;
        endcase

        if (n_out_valid && !(r_out_valid && !i_out_ready)) begin
            n_out_state = r_ctrl;
            n_out_link  = r_link;
            n_out_drop  = r_drop;
            n_out_level = lvl_ext[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_on_irq    <= n_on_irq;
        r_drop      <= n_drop;
        r_pk        <= n_pk;
        r_sk        <= n_sk;
        r_out_kind  <= n_out_kind;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_state <= n_out_state;
        r_out_link  <= n_out_link;
        r_out_drop  <= n_out_drop;
        r_out_level <= n_out_level;
        if (!i_rst_n) begin
            r_bstate    <= B_IDLE;
            r_ctrl      <= LS_FIND;
            r_link      <= 1'b0;
            r_count     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_plen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_bstate    <= n_bstate;
            r_ctrl      <= n_ctrl;
            r_link      <= n_link;
            r_count     <= n_count;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_plen      <= n_plen;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_kind      = r_out_kind;
    assign o_radio_byte     = r_out_byte;
    assign o_last           = r_out_last;
    assign o_ctrl_state_out = r_out_state;
    assign o_link_up_out    = r_out_link;
    assign o_dropped        = r_out_drop;
    assign o_queue_level    = r_out_level;

endmodule

`default_nettype wire

// ===== src/led_update_radio_sequencer_top.sv =====
// LED update queue and radio link sequencer.
// Input channel (i_in_valid / o_in_ready): one request per handshake - queue an
// LED update, report a radio interrupt, or request a plain sequencer step.
// Output channel (o_out_valid / i_out_ready): one item per byte handed to the
// radio, or a single item with byte kind none; o_last marks the final item of
// a request. State, link, drop and queue level repeat on every item.
// A two-entry request queue decouples the input side from the sequencer.
// Per request the sequencer takes one step of its link state machine; for a
// payload it reads k queued updates into the payload RAM (one RAM read per cycle),
// and it sends a payload of n bytes from that RAM while the receiver takes them;
// an interrupt that forces a second step adds one more step.
// Reset: sequencer in find-link, link down, queue and payload empty, no item
// pending; the RAMs need no clearing.
// Receiver stall: the output register holds its item, the sequencer waits,
// and the request queue keeps taking requests until both entries are full.

`default_nettype none

module led_update_radio_sequencer_top
    import lurs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128,
    parameter int PAYLOAD_MAX = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [3:0] i_row,
    input  logic [3:0] i_col,
    input  logic [7:0] i_rgb,
    input  logic       i_max_retry,
    input  logic       i_send_ready,
    input  logic       i_read_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_byte_kind,
    output logic [7:0] o_radio_byte,
    output logic       o_last,
    output logic [2:0] o_ctrl_state_out,
    output logic       o_link_up_out,
    output logic       o_dropped,
    output logic [7:0] o_queue_level
);

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    lurs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_rgb        (i_rgb),
        .i_max_retry  (i_max_retry),
        .i_send_ready (i_send_ready),
        .i_read_ready (i_read_ready),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_ready  (cmd_ready)
    );

    lurs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (cmd_valid),
        .o_cmd_ready      (cmd_ready),
        .i_cmd            (cmd),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_byte_kind      (o_byte_kind),
        .o_radio_byte     (o_radio_byte),
        .o_last           (o_last),
        .o_ctrl_state_out (o_ctrl_state_out),
        .o_link_up_out    (o_link_up_out),
        .o_dropped        (o_dropped),
        .o_queue_level    (o_queue_level)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_kind == KIND_NONE) |-> (o_last && o_radio_byte == 8'd0))
        else $error("empty item not final");

    a_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_kind == KIND_PROBE) |->
        (o_last && o_radio_byte == PROBE_BYTE && o_ctrl_state_out == LS_FIND
         && !o_link_up_out))
        else $error("probe outside find-link");

    a_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_kind == KIND_HEADER) |->
        (o_last && o_ctrl_state_out == LS_WAIT_TX))
        else $error("header state mismatch");

    a_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_kind == KIND_DATA) |-> (o_ctrl_state_out == LS_WAIT_DONE))
        else $error("payload byte state mismatch");

endmodule

`default_nettype wire
